### src/basic_source_tokenizer_top_assert.svh
// Assertion macros shared by the tokenizer modules.
`ifndef BASIC_SOURCE_TOKENIZER_TOP_ASSERT_SVH
`define BASIC_SOURCE_TOKENIZER_TOP_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define BST_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define BST_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

### src/bst_pkg.sv
// ----------------------------------------------------------------------------
// bst_pkg
// Types and codes shared by the source tokenizer: item and result records,
// token kinds, counter limits and the result-pair queue geometry.
// ----------------------------------------------------------------------------
package bst_pkg;

  localparam int unsigned TEXT_W = 12;
  localparam int unsigned LINE_W = 16;

  localparam logic [TEXT_W-1:0] TEXT_LENGTH_LIMIT = 12'd4095;
  localparam logic [LINE_W-1:0] LINE_LIMIT        = 16'd65535;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Token kinds
  localparam logic [4:0] KIND_EOF     = 5'd0;
  localparam logic [4:0] KIND_IDENT   = 5'd1;
  localparam logic [4:0] KIND_INT     = 5'd2;
  localparam logic [4:0] KIND_DOUBLE  = 5'd3;
  localparam logic [4:0] KIND_STRING  = 5'd4;
  localparam logic [4:0] KIND_PLUS    = 5'd5;
  localparam logic [4:0] KIND_MINUS   = 5'd6;
  localparam logic [4:0] KIND_STAR    = 5'd7;
  localparam logic [4:0] KIND_SLASH   = 5'd8;
  localparam logic [4:0] KIND_LPAREN  = 5'd9;
  localparam logic [4:0] KIND_RPAREN  = 5'd10;
  localparam logic [4:0] KIND_COMMA   = 5'd11;
  localparam logic [4:0] KIND_EQ      = 5'd12;
  localparam logic [4:0] KIND_LT      = 5'd13;
  localparam logic [4:0] KIND_LTE     = 5'd14;
  localparam logic [4:0] KIND_NEQ     = 5'd15;
  localparam logic [4:0] KIND_GT      = 5'd16;
  localparam logic [4:0] KIND_GTE     = 5'd17;
  localparam logic [4:0] KIND_AMP     = 5'd18;
  localparam logic [4:0] KIND_DOT     = 5'd19;
  localparam logic [4:0] KIND_AND     = 5'd20;
  localparam logic [4:0] KIND_OR      = 5'd21;
  localparam logic [4:0] KIND_NOT     = 5'd22;
  localparam logic [4:0] KIND_UNKNOWN = 5'd23;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_input;
  } bst_item_t;

  typedef struct packed {
    logic              is_token;
    logic [7:0]        text_byte;
    logic [4:0]        token_kind;
    logic [TEXT_W-1:0] token_length;
    logic [LINE_W-1:0] start_line;
    logic              last_of_run;
  } bst_result_t;

  // Results caused by one input byte: one or two records
  typedef struct packed {
    logic        two;
    bst_result_t first;
    bst_result_t second;
  } bst_pair_t;

endpackage

### src/bst_front.sv
// ----------------------------------------------------------------------------
// bst_front
// Scanner front end: classifies each source byte against the scan state,
// updates line and text counters and forms the one or two result records
// that the byte causes.
// ----------------------------------------------------------------------------
module bst_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  bst_pkg::bst_item_t  item,
  output logic                pair_vld,
  output bst_pkg::bst_pair_t  pair
);
  import bst_pkg::*;

  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_COMMENT  = 3'd1;
  localparam logic [2:0] MODE_IDENT    = 3'd2;
  localparam logic [2:0] MODE_NUMBER   = 3'd3;
  localparam logic [2:0] MODE_STRING   = 3'd4;
  localparam logic [2:0] MODE_HELD_LT  = 3'd5;
  localparam logic [2:0] MODE_HELD_GT  = 3'd6;
  localparam logic [2:0] MODE_HELD_DOT = 3'd7;

  localparam logic [2:0] KW_ALL = 3'b111;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  logic [2:0]        mode, mode_next;
  logic [LINE_W-1:0] line_count, line_next;
  logic [LINE_W-1:0] token_line, tline_next;
  logic [TEXT_W-1:0] text_count, tcount_next;
  logic              seen_dot, dot_next;
  logic [2:0]        kw, kw_next;

  logic [7:0]        b, up;
  logic              in_end, is_digit, is_alpha, is_ident;
  logic [LINE_W-1:0] line_inc;
  logic [TEXT_W-1:0] count_inc;
  logic              flush_vld;
  bst_result_t       flush_res;
  logic [4:0]        ident_kind;
  logic              a0_vld, a1_vld, consumed;
  bst_result_t       a0, a1;

  function automatic bst_result_t make_text(input logic [7:0] ch);
    bst_result_t r;
    r = '0;
    r.text_byte = ch;
    return r;
  endfunction

  function automatic bst_result_t make_token(input logic [4:0] kind, input logic [7:0] ch,
                                             input logic [TEXT_W-1:0] len,
                                             input logic [LINE_W-1:0] line);
    bst_result_t r;
    r = '0;
    r.is_token     = 1'b1;
    r.text_byte    = ch;
    r.token_kind   = kind;
    r.token_length = len;
    r.start_line   = line;
    return r;
  endfunction

  // Drop keyword candidates whose letter at this position does not match
  function automatic logic [2:0] kw_update(input logic [2:0] kw_in,
                                           input logic [TEXT_W-1:0] pos,
                                           input logic [7:0] ch);
    logic keep_and, keep_or, keep_not;
    keep_and = (pos == 12'd0 && ch == "A") || (pos == 12'd1 && ch == "N") ||
               (pos == 12'd2 && ch == "D");
    keep_or  = (pos == 12'd0 && ch == "O") || (pos == 12'd1 && ch == "R");
    keep_not = (pos == 12'd0 && ch == "N") || (pos == 12'd1 && ch == "O") ||
               (pos == 12'd2 && ch == "T");
    return kw_in & {keep_not, keep_or, keep_and};
  endfunction

  // Classify the incoming byte
  assign b        = item.source_byte;
  assign in_end   = item.end_of_input || (b == 8'h00);
  assign is_digit = (b >= "0") && (b <= "9");
  assign is_alpha = ((b >= "A") && (b <= "Z")) || ((b >= "a") && (b <= "z"));
  assign is_ident = is_alpha || is_digit || (b == CH_UNDER);
  assign up       = ((b >= "a") && (b <= "z")) ? (b - 8'd32) : b;

  // Saturating counters
  assign line_inc  = (line_count < LINE_LIMIT) ? (line_count + 16'd1) : line_count;
  assign count_inc = (text_count < TEXT_LENGTH_LIMIT) ? (text_count + 12'd1) : text_count;

  // Resolve identifier kind from surviving keyword candidates
  always_comb begin
    priority if (kw[0] && text_count == 12'd3) begin
      ident_kind = KIND_AND;
    end else if (kw[1] && text_count == 12'd2) begin
      ident_kind = KIND_OR;
    end else if (kw[2] && text_count == 12'd3) begin
      ident_kind = KIND_NOT;
    end else begin
      ident_kind = KIND_IDENT;
    end
  end

  // Token that the pending scan yields when it is cut short
  always_comb begin
    flush_vld = 1'b1;
    flush_res = '0;
    unique case (mode)
      MODE_IDENT:    flush_res = make_token(ident_kind, 8'h00, text_count, token_line);
      MODE_NUMBER:   flush_res = make_token(seen_dot ? KIND_DOUBLE : KIND_INT, 8'h00,
                                            text_count, token_line);
      MODE_STRING:   flush_res = make_token(KIND_STRING, 8'h00, text_count, token_line);
      MODE_HELD_LT:  flush_res = make_token(KIND_LT, 8'h00, '0, token_line);
      MODE_HELD_GT:  flush_res = make_token(KIND_GT, 8'h00, '0, token_line);
      MODE_HELD_DOT: flush_res = make_token(KIND_DOT, 8'h00, '0, token_line);
      MODE_IDLE,
      MODE_COMMENT:  flush_vld = 1'b0;
    endcase
  end

  // Continue the current scan, else flush it and start a new one
  always_comb begin
    mode_next   = mode;
    line_next   = line_count;
    tline_next  = token_line;
    tcount_next = text_count;
    dot_next    = seen_dot;
    kw_next     = kw;
    a0_vld      = 1'b0;
    a1_vld      = 1'b0;
    a0          = '0;
    a1          = '0;
    consumed    = 1'b0;

    if (in_end) begin
      a0_vld      = flush_vld;
      a0          = flush_res;
      a1_vld      = 1'b1;
      a1          = make_token(KIND_EOF, 8'h00, '0, line_count);
      mode_next   = MODE_IDLE;
      line_next   = 16'd1;
      tline_next  = 16'd1;
      tcount_next = '0;
      dot_next    = 1'b0;
      kw_next     = KW_ALL;
    end else begin
      unique case (mode)
        MODE_COMMENT: begin
          consumed = 1'b1;
          if (b == CH_LF) begin
            line_next = line_inc;
            mode_next = MODE_IDLE;
          end
        end
        MODE_IDENT: begin
          if (is_ident) begin
            consumed    = 1'b1;
            kw_next     = kw_update(kw, text_count, up);
            a0_vld      = 1'b1;
            a0          = make_text(b);
            tcount_next = count_inc;
          end
        end
        MODE_NUMBER: begin
          if (is_digit || (b == CH_DOT && !seen_dot)) begin
            consumed    = 1'b1;
            if (b == CH_DOT) begin
              dot_next = 1'b1;
            end
            a0_vld      = 1'b1;
            a0          = make_text(b);
            tcount_next = count_inc;
          end
        end
        MODE_STRING: begin
          consumed = 1'b1;
          if (b == CH_QUOTE) begin
            a0_vld    = 1'b1;
            a0        = make_token(KIND_STRING, 8'h00, text_count, token_line);
            mode_next = MODE_IDLE;
          end else begin
            if (b == CH_LF) begin
              line_next = line_inc;
            end
            a0_vld      = 1'b1;
            a0          = make_text(b);
            tcount_next = count_inc;
          end
        end
        MODE_HELD_LT: begin
          if (b == CH_GT || b == CH_EQ) begin
            consumed  = 1'b1;
            a0_vld    = 1'b1;
            a0        = make_token((b == CH_GT) ? KIND_NEQ : KIND_LTE, 8'h00, '0, token_line);
            mode_next = MODE_IDLE;
          end
        end
        MODE_HELD_GT: begin
          if (b == CH_EQ) begin
            consumed  = 1'b1;
            a0_vld    = 1'b1;
            a0        = make_token(KIND_GTE, 8'h00, '0, token_line);
            mode_next = MODE_IDLE;
          end
        end
        MODE_HELD_DOT: begin
          // leading dot turns into a double
          if (is_digit) begin
            consumed    = 1'b1;
            a0_vld      = 1'b1;
            a0          = make_text(CH_DOT);
            a1_vld      = 1'b1;
            a1          = make_text(b);
            tcount_next = 12'd2;
            dot_next    = 1'b1;
            mode_next   = MODE_NUMBER;
          end
        end
        MODE_IDLE: begin
          consumed = 1'b0;
        end
      endcase

      if (!consumed) begin
        a0_vld      = flush_vld;
        a0          = flush_res;
        mode_next   = MODE_IDLE;
        tline_next  = line_count;
        tcount_next = '0;
        dot_next    = 1'b0;
        kw_next     = KW_ALL;
        a1_vld      = 1'b1;
        priority if (b == CH_SPACE || b == CH_TAB || b == CH_CR) begin
          a1_vld = 1'b0;
        end else if (b == CH_LF) begin
          a1_vld    = 1'b0;
          line_next = line_inc;
        end else if (b == CH_APOS) begin
          a1_vld    = 1'b0;
          mode_next = MODE_COMMENT;
        end else if (b == CH_QUOTE) begin
          a1_vld    = 1'b0;
          mode_next = MODE_STRING;
        end else if (is_digit) begin
          a1          = make_text(b);
          mode_next   = MODE_NUMBER;
          tcount_next = 12'd1;
        end else if (is_ident) begin
          a1          = make_text(b);
          mode_next   = MODE_IDENT;
          kw_next     = kw_update(KW_ALL, '0, up);
          tcount_next = 12'd1;
        end else if (b == CH_DOT) begin
          a1_vld    = 1'b0;
          mode_next = MODE_HELD_DOT;
        end else if (b == CH_LT) begin
          a1_vld    = 1'b0;
          mode_next = MODE_HELD_LT;
        end else if (b == CH_GT) begin
          a1_vld    = 1'b0;
          mode_next = MODE_HELD_GT;
        end else if (b == CH_PLUS) begin
          a1 = make_token(KIND_PLUS, 8'h00, '0, line_count);
        end else if (b == CH_MINUS) begin
          a1 = make_token(KIND_MINUS, 8'h00, '0, line_count);
        end else if (b == CH_STAR) begin
          a1 = make_token(KIND_STAR, 8'h00, '0, line_count);
        end else if (b == CH_SLASH) begin
          a1 = make_token(KIND_SLASH, 8'h00, '0, line_count);
        end else if (b == CH_LPAR) begin
          a1 = make_token(KIND_LPAREN, 8'h00, '0, line_count);
        end else if (b == CH_RPAR) begin
          a1 = make_token(KIND_RPAREN, 8'h00, '0, line_count);
        end else if (b == CH_COMMA) begin
          a1 = make_token(KIND_COMMA, 8'h00, '0, line_count);
        end else if (b == CH_EQ) begin
          a1 = make_token(KIND_EQ, 8'h00, '0, line_count);
        end else if (b == CH_AMP) begin
          a1 = make_token(KIND_AMP, 8'h00, '0, line_count);
        end else begin
          a1 = make_token(KIND_UNKNOWN, b, '0, line_count);
        end
      end
    end
  end

  // Pack the records in order and mark the last one
  always_comb begin
    pair_vld = a0_vld || a1_vld;
    pair     = '0;
    if (a0_vld) begin
      pair.first  = a0;
      pair.second = a1;
      pair.two    = a1_vld;
    end else begin
      pair.first  = a1;
    end
    if (pair.two) begin
      pair.second.last_of_run = 1'b1;
    end else begin
      pair.first.last_of_run  = 1'b1;
    end
  end

  // Advance scan state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      line_count <= 16'd1;
      token_line <= 16'd1;
      text_count <= '0;
      seen_dot   <= 1'b0;
      kw         <= KW_ALL;
    end else if (take) begin
      mode       <= mode_next;
      line_count <= line_next;
      token_line <= tline_next;
      text_count <= tcount_next;
      seen_dot   <= dot_next;
      kw         <= kw_next;
    end
  end

endmodule

### src/bst_queue.sv
// ----------------------------------------------------------------------------
// bst_queue
// Short first-in first-out queue of result pairs between the scanner and
// the output side.
// ----------------------------------------------------------------------------
`include "basic_source_tokenizer_top_assert.svh"

module bst_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  bst_pkg::bst_pair_t wr_data,
  input  logic               rd_en,
  output bst_pkg::bst_pair_t rd_data,
  output logic               empty,
  output logic               full
);
  import bst_pkg::*;

  bst_pair_t           slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_wr, do_rd;

  assign empty   = (count == '0);
  assign full    = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // Store incoming pairs
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  `BST_ASSERT_NEXT(a_fill_up, clk, rst, do_wr && !do_rd, count == $past(count) + 1'b1, "queue fill did not rise on write")
  `BST_ASSERT_NEXT(a_empty_hold, clk, rst, empty && !wr_en, empty, "queue left empty without a write")

endmodule

### src/bst_back.sv
// ----------------------------------------------------------------------------
// bst_back
// Output side: presents the records of the oldest queued pair one at a
// time and releases the pair once its last record has been transferred.
// ----------------------------------------------------------------------------
`include "basic_source_tokenizer_top_assert.svh"

module bst_back (
  input  logic                 clk,
  input  logic                 rst,
  input  bst_pkg::bst_pair_t   head,
  input  logic                 q_empty,
  output logic                 q_pop,
  input  logic                 pop,
  output logic                 empty,
  output bst_pkg::bst_result_t result
);
  import bst_pkg::*;

  logic sel;
  logic xfer;

  assign empty  = q_empty;
  assign result = sel ? head.second : head.first;
  assign xfer   = pop && !q_empty;
  assign q_pop  = xfer && (sel || !head.two);

  // Step to the second record, or release the pair
  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else if (xfer) begin
      sel <= !sel && head.two;
    end
  end

  `BST_ASSERT_NOW(a_sel_pair, clk, rst, sel, !q_empty && head.two, "second record selected without a pair")
  `BST_ASSERT_NOW(a_last_mark, clk, rst, !q_empty, result.last_of_run == (sel || !head.two), "last record mark out of place")

endmodule

### src/basic_source_tokenizer_top.sv
// ----------------------------------------------------------------------------
// basic_source_tokenizer_top
// Streaming lexer for BASIC-like source text, queue handshake on both sides.
// ----------------------------------------------------------------------------
// One source byte is taken per clock cycle while full is low. Each byte
// causes zero, one or two result records: text records for the bytes of a
// token's text, token records when a token completes. The scanner settles
// a byte in the cycle it is transferred; its records enter a four-entry
// queue of result pairs and leave on the result side one per cycle of pop,
// so a result shows once its pair is registered in the queue and every
// record ahead has left. Input runs at one byte per cycle for as long as
// the result side keeps up on average; full rises when four pairs are
// waiting. No clearing pass follows reset.
module basic_source_tokenizer_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  bst_pkg::bst_item_t   item,
  output logic                 empty,
  input  logic                 pop,
  output bst_pkg::bst_result_t result
);
  import bst_pkg::*;

  logic      take;
  logic      pair_vld;
  bst_pair_t pair;
  bst_pair_t head;
  logic      q_empty;
  logic      q_pop;

  assign take = push && !full;

  // Scan and classify incoming bytes
  bst_front u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .item     (item),
    .pair_vld (pair_vld),
    .pair     (pair)
  );

  // Buffer result pairs
  bst_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (take && pair_vld),
    .wr_data (pair),
    .rd_en   (q_pop),
    .rd_data (head),
    .empty   (q_empty),
    .full    (full)
  );

  // Hand out records one per transfer
  bst_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

### test/basic_source_tokenizer_top_tb.sv
// ----------------------------------------------------------------------------
// basic_source_tokenizer_top_tb
// Self-checking bench for the streaming BASIC source tokenizer.
// ----------------------------------------------------------------------------
// A short table of hand-picked source bytes comes first: operators, held
// lookahead characters, keywords, comments, strings across lines and both
// kinds of end of input. Random source fragments follow: words and
// keywords, numbers, strings, operators, comments, blanks, stray bytes and
// ends of input. Every transferred byte runs through a lexer model kept in
// the bench; each record popped from the block is compared field by field
// with the oldest predicted record.
// ----------------------------------------------------------------------------
module basic_source_tokenizer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bst_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 7;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_ITEMS  = 1075;
  localparam int PHASE_ITEMS   = 250;
  localparam int HOLD_CYCLES   = 150;
  localparam int DRAIN_CYCLES  = 40;
  localparam int MAX_GAP       = 12;
  localparam int MAX_PRINTED   = 60;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;

  typedef enum logic [3:0] {
    LEX_IDLE,
    LEX_COMMENT,
    LEX_IDENT,
    LEX_NUMBER,
    LEX_STRING,
    LEX_HELD_LT,
    LEX_HELD_GT,
    LEX_HELD_DOT
  } lex_mode_e;

  typedef struct {
    logic [7:0]  ch;
    logic        eoi;
    logic        typed;
    bst_result_t res;
  } stim_row_t;

  logic        clk   = 1'b0;
  logic        rst   = 1'b1;
  logic        push  = 1'b0;
  logic        pop   = 1'b0;
  bst_item_t   item  = '0;
  logic        full;
  logic        empty;
  bst_result_t result;

  // Lexer model state
  lex_mode_e   lex_mode;
  logic [15:0] lex_line;
  logic [15:0] lex_tok_line;
  logic [11:0] lex_len;
  logic        lex_dot;
  logic [2:0]  lex_kw;
  bst_result_t step_recs [2];
  int          step_n;

  string       kw_words [3] = '{"AND", "OR", "NOT"};
  logic [4:0]  kw_kinds [3] = '{KIND_AND, KIND_OR, KIND_NOT};

  bst_result_t pending_records [$];
  bst_item_t   source_run [$];
  int          errors       = 0;
  int          records_seen = 0;
  int unsigned cycle_count  = 0;
  bit          send_idle    = 1'b1;
  bit          recv_idle    = 1'b1;
  bit          hold_req     = 1'b0;

  // Hand-picked opening sequence; typed rows carry their one record
  stim_row_t dir_table [26] = '{
    '{8'hFF,    1'b1, 1'b1, '{1'b1, 8'h00, KIND_EOF, 12'd0, 16'd1, 1'b1}},
    '{"+",      1'b0, 1'b1, '{1'b1, 8'h00, KIND_PLUS, 12'd0, 16'd1, 1'b1}},
    '{8'hFF,    1'b0, 1'b1, '{1'b1, 8'hFF, KIND_UNKNOWN, 12'd0, 16'd1, 1'b1}},
    '{".",      1'b0, 1'b0, '0},
    '{"5",      1'b0, 1'b0, '0},
    '{".",      1'b0, 1'b0, '0},
    '{"x",      1'b0, 1'b0, '0},
    '{CH_APOS,  1'b0, 1'b0, '0},
    '{"q",      1'b0, 1'b0, '0},
    '{CH_LF,    1'b0, 1'b0, '0},
    '{"n",      1'b0, 1'b0, '0},
    '{"O",      1'b0, 1'b0, '0},
    '{"t",      1'b0, 1'b0, '0},
    '{"<",      1'b0, 1'b0, '0},
    '{">",      1'b0, 1'b0, '0},
    '{">",      1'b0, 1'b0, '0},
    '{"=",      1'b0, 1'b0, '0},
    '{"<",      1'b0, 1'b0, '0},
    '{"=",      1'b0, 1'b0, '0},
    '{CH_QUOTE, 1'b0, 1'b0, '0},
    '{CH_LF,    1'b0, 1'b0, '0},
    '{8'h80,    1'b0, 1'b0, '0},
    '{8'h00,    1'b0, 1'b0, '0},
    '{"O",      1'b0, 1'b0, '0},
    '{"r",      1'b0, 1'b0, '0},
    '{"A",      1'b1, 1'b0, '0}
  };

  basic_source_tokenizer_top dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("basic_source_tokenizer_top test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- lexer model

  function automatic bit is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  task automatic lex_reset();
    lex_mode     = LEX_IDLE;
    lex_line     = 16'd1;
    lex_tok_line = 16'd1;
    lex_len      = '0;
    lex_dot      = 1'b0;
    lex_kw       = 3'b111;
  endtask

  task automatic add_rec(logic tok, logic [7:0] b, logic [4:0] kind, logic [11:0] len);
    bst_result_t r;
    if (step_n >= 2) return;
    r.is_token     = tok;
    r.text_byte    = b;
    r.token_kind   = kind;
    r.token_length = len;
    r.start_line   = tok ? lex_tok_line : '0;
    r.last_of_run  = 1'b0;
    step_recs[step_n] = r;
    step_n++;
  endtask

  task automatic add_text(logic [7:0] b);
    add_rec(1'b0, b, '0, '0);
  endtask

  task automatic add_token(logic [4:0] kind);
    add_rec(1'b1, '0, kind, '0);
  endtask

  task automatic count_up();
    if (lex_len < TEXT_LENGTH_LIMIT) lex_len++;
  endtask

  task automatic line_up();
    if (lex_line < LINE_LIMIT) lex_line++;
  endtask

  // Drop keyword candidates that no longer match the text so far
  task automatic kw_step(logic [7:0] b);
    logic [7:0] u;
    u = (b >= "a" && b <= "z") ? b - 8'd32 : b;
    for (int k = 0; k < 3; k++) begin
      if (lex_kw[k] && (lex_len >= kw_words[k].len() || kw_words[k][lex_len] != u))
        lex_kw[k] = 1'b0;
    end
  endtask

  function automatic logic [4:0] ident_kind();
    for (int k = 0; k < 3; k++) begin
      if (lex_kw[k] && lex_len == kw_words[k].len()) return kw_kinds[k];
    end
    return KIND_IDENT;
  endfunction

  // Close whatever token is open
  task automatic lex_flush();
    case (lex_mode)
      LEX_IDENT:    add_rec(1'b1, '0, ident_kind(), lex_len);
      LEX_NUMBER:   add_rec(1'b1, '0, lex_dot ? KIND_DOUBLE : KIND_INT, lex_len);
      LEX_STRING:   add_rec(1'b1, '0, KIND_STRING, lex_len);
      LEX_HELD_LT:  add_token(KIND_LT);
      LEX_HELD_GT:  add_token(KIND_GT);
      LEX_HELD_DOT: add_token(KIND_DOT);
      default: ;
    endcase
    lex_mode = LEX_IDLE;
  endtask

  // Offer the byte to the open token; flush it when the byte does not fit
  task automatic lex_continue(logic [7:0] b, output bit taken);
    taken = 1'b0;
    case (lex_mode)
      LEX_COMMENT: begin
        taken = 1'b1;
        if (b == CH_LF) begin
          line_up();
          lex_mode = LEX_IDLE;
        end
      end
      LEX_IDENT: begin
        if (is_alpha(b) || is_digit(b) || b == "_") begin
          kw_step(b);
          add_text(b);
          count_up();
          taken = 1'b1;
        end
      end
      LEX_NUMBER: begin
        if (is_digit(b) || (b == "." && !lex_dot)) begin
          if (b == ".") lex_dot = 1'b1;
          add_text(b);
          count_up();
          taken = 1'b1;
        end
      end
      LEX_STRING: begin
        taken = 1'b1;
        if (b == CH_QUOTE) begin
          add_rec(1'b1, '0, KIND_STRING, lex_len);
          lex_mode = LEX_IDLE;
        end else begin
          if (b == CH_LF) line_up();
          add_text(b);
          count_up();
        end
      end
      LEX_HELD_LT: begin
        if (b == ">" || b == "=") begin
          add_token(b == ">" ? KIND_NEQ : KIND_LTE);
          lex_mode = LEX_IDLE;
          taken = 1'b1;
        end
      end
      LEX_HELD_GT: begin
        if (b == "=") begin
          add_token(KIND_GTE);
          lex_mode = LEX_IDLE;
          taken = 1'b1;
        end
      end
      LEX_HELD_DOT: begin
        if (is_digit(b)) begin
          add_text(".");
          add_text(b);
          lex_len = '0;
          count_up();
          count_up();
          lex_dot  = 1'b1;
          lex_mode = LEX_NUMBER;
          taken = 1'b1;
        end
      end
      default: ;
    endcase
    if (!taken) lex_flush();
  endtask

  // Open a new token, or skip a blank
  task automatic lex_start(logic [7:0] b);
    lex_tok_line = lex_line;
    lex_len      = '0;
    lex_dot      = 1'b0;
    lex_kw       = 3'b111;
    if (b == " " || b == CH_TAB || b == CH_CR) begin
    end else if (b == CH_LF) begin
      line_up();
    end else if (b == CH_APOS) begin
      lex_mode = LEX_COMMENT;
    end else if (b == CH_QUOTE) begin
      lex_mode = LEX_STRING;
    end else if (is_digit(b)) begin
      lex_mode = LEX_NUMBER;
      add_text(b);
      count_up();
    end else if (is_alpha(b) || b == "_") begin
      lex_mode = LEX_IDENT;
      kw_step(b);
      add_text(b);
      count_up();
    end else begin
      case (b)
        ".":     lex_mode = LEX_HELD_DOT;
        "<":     lex_mode = LEX_HELD_LT;
        ">":     lex_mode = LEX_HELD_GT;
        "+":     add_token(KIND_PLUS);
        "-":     add_token(KIND_MINUS);
        "*":     add_token(KIND_STAR);
        "/":     add_token(KIND_SLASH);
        "(":     add_token(KIND_LPAREN);
        ")":     add_token(KIND_RPAREN);
        ",":     add_token(KIND_COMMA);
        "=":     add_token(KIND_EQ);
        "&":     add_token(KIND_AMP);
        default: add_rec(1'b1, b, KIND_UNKNOWN, '0);
      endcase
    end
  endtask

  // Work out the records caused by one transferred byte
  task automatic lex_byte(bst_item_t it);
    bit         taken;
    logic [7:0] b;
    b = it.source_byte;
    step_n = 0;
    if (it.end_of_input || b == 8'h00) begin
      lex_flush();
      lex_tok_line = lex_line;
      add_token(KIND_EOF);
      lex_reset();
    end else begin
      lex_continue(b, taken);
      if (!taken) lex_start(b);
    end
    if (step_n > 0) step_recs[step_n - 1].last_of_run = 1'b1;
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string msg);
    if (errors < MAX_PRINTED) $display("MISMATCH at record %0d: %s", records_seen, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // ---------------------------------------------------------------- source side

  // Offer one byte after a drawn gap, hold it until transferred
  task automatic send_item(bst_item_t it, bit typed, bst_result_t typed_res);
    int gap;
    gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    lex_byte(it);
    if (typed) begin
      pending_records.push_back(typed_res);
    end else begin
      for (int i = 0; i < step_n; i++) pending_records.push_back(step_recs[i]);
    end
  endtask

  task automatic queue_byte(logic [7:0] b);
    bst_item_t it;
    it.source_byte  = b;
    it.end_of_input = 1'b0;
    source_run.push_back(it);
  endtask

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(0, 1) ? "A" : "a") + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return "0" + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_body_byte();
    logic [7:0] b;
    b = 8'($urandom_range(1, 255));
    return (b == CH_QUOTE) ? "a" : b;
  endfunction

  // Build one random source fragment; blanks and comments do not count
  task automatic build_fragment(output bit counts);
    string      ops;
    string      blanks;
    bst_item_t  it;
    int         r;
    int         n;
    int         k;
    logic [7:0] c;
    ops    = "+-*/(),=&<>.";
    blanks = string'({" ", CH_TAB, CH_CR, CH_LF});
    counts = 1'b1;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      // keyword, sometimes cut short or extended
      k = $urandom_range(0, 2);
      n = kw_words[k].len() - (($urandom_range(0, 5) == 0) ? 1 : 0);
      for (int i = 0; i < n; i++) begin
        c = kw_words[k][i];
        queue_byte($urandom_range(0, 1) ? c : c + 8'd32);
      end
      if ($urandom_range(0, 5) == 0) queue_byte($urandom_range(0, 1) ? "_" : rand_digit());
      queue_byte(" ");
    end else if (r < 20) begin
      // identifier
      queue_byte($urandom_range(0, 4) == 0 ? "_" : rand_letter());
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++) begin
        k = $urandom_range(0, 5);
        queue_byte(k == 0 ? "_" : (k == 1 ? rand_digit() : rand_letter()));
      end
    end else if (r < 33) begin
      // integer or decimal, leading dot or a second dot now and then
      if ($urandom_range(0, 4) == 0) queue_byte(".");
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) queue_byte(rand_digit());
      if ($urandom_range(0, 1)) begin
        queue_byte(".");
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) queue_byte(rand_digit());
      end
      if ($urandom_range(0, 4) == 0) queue_byte(".");
    end else if (r < 43) begin
      // string, mostly closed
      queue_byte(CH_QUOTE);
      n = $urandom_range(0, 8);
      for (int i = 0; i < n; i++)
        queue_byte($urandom_range(0, 5) == 0 ? CH_LF : rand_body_byte());
      if ($urandom_range(0, 6) != 0) queue_byte(CH_QUOTE);
    end else if (r < 61) begin
      // operator or punctuation, sometimes a compound
      queue_byte(ops[$urandom_range(0, ops.len() - 1)]);
      if ($urandom_range(0, 2) == 0) queue_byte(ops[$urandom_range(7, 10)]);
    end else if (r < 71) begin
      queue_byte(blanks[$urandom_range(0, 3)]);
      counts = 1'b0;
    end else if (r < 77) begin
      // comment, mostly closed by a line feed
      queue_byte(CH_APOS);
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) queue_byte(rand_body_byte());
      if ($urandom_range(0, 4) != 0) queue_byte(CH_LF);
      counts = 1'b0;
    end else if (r < 95) begin
      queue_byte(8'($urandom_range(1, 255)));
    end else begin
      // end of input, by flag or by a zero byte
      it.end_of_input = 1'($urandom_range(0, 1));
      it.source_byte  = it.end_of_input ? 8'($urandom_range(0, 255)) : 8'h00;
      source_run.push_back(it);
    end
  endtask

  // ---------------------------------------------------------------- result side

  initial begin
    int          stall;
    bst_result_t got;
    bst_result_t want;
    wait (!rst);
    forever begin
      @(negedge clk);
      stall = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      got = result;
      if (pending_records.size() == 0) begin
        report_mismatch($sformatf("unexpected record is_token=%0d byte=%0h kind=%0d",
                                  got.is_token, got.text_byte, got.token_kind));
      end else begin
        want = pending_records.pop_front();
        check_field("is_token", 16'(got.is_token), 16'(want.is_token));
        check_field("text_byte", 16'(got.text_byte), 16'(want.text_byte));
        check_field("token_kind", 16'(got.token_kind), 16'(want.token_kind));
        check_field("token_length", 16'(got.token_length), 16'(want.token_length));
        check_field("start_line", got.start_line, want.start_line);
        check_field("last_of_run", 16'(got.last_of_run), 16'(want.last_of_run));
      end
      records_seen++;
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    bst_item_t it;
    int        counted;
    int        phase;
    bit        counts;
    bit        hold_given;
    lex_reset();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the opening table
    foreach (dir_table[i]) begin
      it.source_byte  = dir_table[i].ch;
      it.end_of_input = dir_table[i].eoi;
      send_item(it, dir_table[i].typed, dir_table[i].res);
    end

    // Random fragments in phases of differing pressure
    counted    = 0;
    hold_given = 1'b0;
    while (counted < RANDOM_ITEMS) begin
      phase = counted / PHASE_ITEMS;
      case (phase)
        1:       begin send_idle = 1'b0; recv_idle = 1'b0; end
        2:       begin send_idle = 1'b1; recv_idle = 1'b0; end
        3:       begin send_idle = 1'b0; recv_idle = 1'b1; end
        default: begin send_idle = 1'b1; recv_idle = 1'b1; end
      endcase
      if (phase == 1 && !hold_given) begin
        hold_req   = 1'b1;
        hold_given = 1'b1;
      end
      build_fragment(counts);
      if (counts) counted += source_run.size();
      while (source_run.size() > 0) send_item(source_run.pop_front(), 1'b0, '0);
    end
    @(negedge clk);
    push <= 1'b0;

    // Drain, then allow any stray record to show up
    while (pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!empty) report_mismatch("records left waiting after the drain");
    if (errors == 0) begin
      $display("basic_source_tokenizer_top test passed");
    end else begin
      $display("basic_source_tokenizer_top test failed");
    end
    $finish;
  end

endmodule
